// File: hw/rtl/snc_pkg.sv
// Shared types and constants for the spiking neuron core.
package snc_pkg;

    localparam int IDX_W     = 8;
    localparam int DATA_W    = 32;
    localparam int DECAY_W   = 11;
    localparam int CFG_W     = 16;
    localparam int FRAC_BITS = 10;
    localparam int FACTOR_W  = 12;
    localparam int PROD_W    = DATA_W + FACTOR_W;

    localparam logic signed [FACTOR_W-1:0] GAIN_MIN  = 12'sd64;
    localparam logic signed [FACTOR_W-1:0] GAIN_MAX  = 12'sd1024;
    localparam logic [FACTOR_W-1:0]        UNITY     = 12'd1024;
    localparam logic signed [DATA_W-1:0]   THR_FLOOR = 32'sd1024;

    typedef enum logic [1:0] {
        KIND_SYNAPSE = 2'd0,
        KIND_UPDATE  = 2'd1,
        KIND_LOAD    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        COMP_PROXIMAL = 2'd0,
        COMP_DISTAL   = 2'd1
    } t_comp;

    typedef enum logic [0:0] {
        CFG_THR_RAISE = 1'b0,
        CFG_THR_LOWER = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OP_SYN_PROX,
        OP_SYN_DIST,
        OP_UPDATE,
        OP_LOAD
    } t_op;

    typedef struct packed {
        logic [1:0]                kind;
        logic [IDX_W-1:0]          source_index;
        logic [IDX_W-1:0]          neuron_index;
        logic signed [DATA_W-1:0]  weight;
        logic [1:0]                compartment;
        logic signed [DATA_W-1:0]  load_threshold;
        logic [DECAY_W-1:0]        load_decay;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]          out_index;
        logic                      fired;
        logic signed [DATA_W-1:0]  potential_out;
        logic signed [DATA_W-1:0]  threshold_out;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   src;
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  data;
        logic [DECAY_W-1:0] decay;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] thr_raise;
        logic [CFG_W-1:0] thr_lower;
    } t_cfg;

endpackage

// File: hw/rtl/snc_front.sv
// Input stage: accepts beats, drops ignored items and queues neuron commands.
module snc_front
    import snc_pkg::*;
#(
    parameter int NEURONS = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_item i_in_data,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output t_cmd     o_cmd,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready
);

    t_cmd        r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    t_cmd        cls;
    logic        idx_ok;
    logic        src_ok;
    logic        keep;
    logic        accept;
    logic        push;
    logic        pop;

    always_comb begin
        idx_ok    = (32'(i_in_data.neuron_index) < NEURONS);
        src_ok    = (32'(i_in_data.source_index) < NEURONS);
        cls.op    = OP_LOAD;
        cls.src   = i_in_data.source_index;
        cls.idx   = i_in_data.neuron_index;
        cls.data  = i_in_data.weight;
        cls.decay = i_in_data.load_decay;
        keep      = 1'b0;
        case (i_in_data.kind)
            KIND_SYNAPSE: begin
                keep   = idx_ok && src_ok &&
                         (i_in_data.compartment == COMP_PROXIMAL ||
                          i_in_data.compartment == COMP_DISTAL);
                cls.op = (i_in_data.compartment == COMP_DISTAL) ? OP_SYN_DIST : OP_SYN_PROX;
            end
            KIND_UPDATE: begin
                keep   = idx_ok;
                cls.op = OP_UPDATE;
            end
            KIND_LOAD: begin
                keep     = idx_ok;
                cls.op   = OP_LOAD;
                cls.data = i_in_data.load_threshold;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign accept      = i_in_valid && !o_in_stall;
    assign push        = accept && keep;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign n_count     = r_count + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

// File: hw/rtl/snc_back.sv
// Execution stage: neuron tables, synapse accumulation and the update datapath.
module snc_back
    import snc_pkg::*;
#(
    parameter int NEURONS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cfg      i_cfg,
    output t_out_item o_out_data,
    output logic      o_out_valid,
    input  logic      i_out_stall
);

    localparam int DEPTH = (NEURONS < 256) ? NEURONS : 256;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SYNAPSE,
        S_GATE,
        S_SUM,
        S_DECAY,
        S_DONE
    } t_state;

    t_state                      r_state;
    t_cmd                        r_cmd;
    logic [DEPTH-1:0]            r_vld;
    logic [DEPTH-1:0]            r_spk;
    logic                        r_out_valid;
    t_out_item                   r_out;

    logic [DATA_W-1:0]           mem_membrane [DEPTH];
    logic [DATA_W-1:0]           mem_prox     [DEPTH];
    logic [DATA_W-1:0]           mem_dist     [DEPTH];
    logic [DATA_W-1:0]           mem_fire     [DEPTH];
    logic [DECAY_W-1:0]          mem_leak     [DEPTH];

    logic [DATA_W-1:0]           r_rd_membrane;
    logic [DATA_W-1:0]           r_rd_prox;
    logic [DATA_W-1:0]           r_rd_dist;
    logic [DATA_W-1:0]           r_rd_fire;
    logic [DECAY_W-1:0]          r_rd_leak;

    logic signed [PROD_W-1:0]    r_gated_prod;
    logic [DATA_W-1:0]           r_m;
    logic [DATA_W-1:0]           r_p;
    logic [DATA_W-1:0]           r_fire;
    logic [DECAY_W-1:0]          r_leak;
    logic [DATA_W-1:0]           r_sum;
    logic signed [PROD_W-1:0]    r_decay_prod;

    logic [15:0]                 idx_ext;
    logic [15:0]                 src_ext;
    logic [AW-1:0]               addr;
    logic [AW-1:0]               src_addr;
    logic                        out_free;
    logic [DATA_W-1:0]           cur_m;
    logic [DATA_W-1:0]           cur_p;
    logic signed [DATA_W-1:0]    cur_d;
    logic signed [FACTOR_W-1:0]  gain;
    logic signed [FACTOR_W-1:0]  factor;
    logic signed [DATA_W-1:0]    decayed;
    logic signed [DATA_W-1:0]    fire_s;
    logic                        fired;
    logic [DATA_W-1:0]           new_thr;

    logic                        we_state;
    logic                        we_param;
    logic [DATA_W-1:0]           wr_m;
    logic [DATA_W-1:0]           wr_p;
    logic [DATA_W-1:0]           wr_d;
    logic [DATA_W-1:0]           wr_fire;
    logic [DECAY_W-1:0]          wr_leak;

    assign idx_ext     = {8'd0, r_cmd.idx};
    assign src_ext     = {8'd0, r_cmd.src};
    assign addr        = idx_ext[AW-1:0];
    assign src_addr    = src_ext[AW-1:0];
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        cur_m = r_vld[addr] ? r_rd_membrane : '0;
        cur_p = r_vld[addr] ? r_rd_prox : '0;
        cur_d = r_vld[addr] ? $signed(r_rd_dist) : '0;

        if ($signed(cur_p) < GAIN_MIN) begin
            gain = GAIN_MIN;
        end else if ($signed(cur_p) > GAIN_MAX) begin
            gain = GAIN_MAX;
        end else begin
            gain = $signed(cur_p[FACTOR_W-1:0]);
        end

        factor  = $signed(UNITY - {1'b0, r_leak});
        decayed = r_decay_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
        fire_s  = $signed(r_fire);
        fired   = (decayed >= fire_s);
        if (fired) begin
            new_thr = r_fire + {{(DATA_W-CFG_W){1'b0}}, i_cfg.thr_raise};
        end else if (fire_s > THR_FLOOR) begin
            new_thr = r_fire - {{(DATA_W-CFG_W){1'b0}}, i_cfg.thr_lower};
        end else begin
            new_thr = r_fire;
        end

        we_state = 1'b0;
        we_param = 1'b0;
        wr_m     = cur_m;
        wr_p     = cur_p;
        wr_d     = cur_d;
        wr_fire  = r_cmd.data;
        wr_leak  = r_cmd.decay;
        case (r_state)
            S_READ: begin
                we_param = (r_cmd.op == OP_LOAD);
            end
            S_SYNAPSE: begin
                we_state = 1'b1;
                if (r_cmd.op == OP_SYN_DIST) begin
                    wr_d = cur_d + r_cmd.data;
                end else begin
                    wr_p = cur_p + r_cmd.data;
                end
            end
            S_DONE: begin
                we_state = out_free;
                we_param = out_free;
                wr_m     = fired ? '0 : decayed;
                wr_p     = '0;
                wr_d     = '0;
                wr_fire  = new_thr;
                wr_leak  = r_leak;
            end
            default: begin
                we_state = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_state) begin
            mem_membrane[addr] <= wr_m;
            mem_prox[addr]     <= wr_p;
            mem_dist[addr]     <= wr_d;
        end
        if (we_param) begin
            mem_fire[addr] <= wr_fire;
            mem_leak[addr] <= wr_leak;
        end
        r_rd_membrane <= mem_membrane[addr];
        r_rd_prox     <= mem_prox[addr];
        r_rd_dist     <= mem_dist[addr];
        r_rd_fire     <= mem_fire[addr];
        r_rd_leak     <= mem_leak[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_spk       <= '0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    case (r_cmd.op)
                        OP_LOAD: begin
                            r_vld[addr] <= 1'b0;
                            r_spk[addr] <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                        OP_UPDATE: begin
                            r_state <= S_GATE;
                        end
                        default: begin
                            r_state <= r_spk[src_addr] ? S_SYNAPSE : S_IDLE;
                        end
                    endcase
                end
                S_SYNAPSE: begin
                    r_vld[addr] <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_GATE: begin
                    r_gated_prod <= cur_d * gain;
                    r_m          <= cur_m;
                    r_p          <= cur_p;
                    r_fire       <= r_rd_fire;
                    r_leak       <= r_rd_leak;
                    r_state      <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= r_m + r_p + r_gated_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
                    r_state <= S_DECAY;
                end
                S_DECAY: begin
                    r_decay_prod <= $signed(r_sum) * factor;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.out_index     <= r_cmd.idx;
                        r_out.fired         <= fired;
                        r_out.potential_out <= fired ? '0 : decayed;
                        r_out.threshold_out <= new_thr;
                        r_vld[addr]         <= 1'b1;
                        r_spk[addr]         <= fired;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_done_publishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_spk[addr] == r_out.fired))
        else $error("update result or spike bit not stored after completion");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside update completion");

    a_synapse_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SYNAPSE) |->
            ($past(r_state == S_READ) && $past(r_spk[src_addr]) &&
             r_cmd.op != OP_UPDATE && r_cmd.op != OP_LOAD))
        else $error("synapse accumulated without a set source spike bit");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == S_READ && r_cmd.op == OP_LOAD) |-> (!r_vld[addr] && !r_spk[addr]))
        else $error("load did not clear neuron state");
`endif

endmodule

// File: hw/rtl/spiking_neuron_core.sv
// Top level of the spiking neuron core: configuration registers and stage wiring.
// The execution stage takes a queued command in its idle state, then steps through read on a
// load; read, then synapse only when the source spike bit is set, on a synapse beat; and
// read, gate, sum, decay and done on an update, whose result beat is registered in done,
// which waits while an earlier result is stalled; the update holds two registered multiplies.
// Reset clears the valid and spike bits, so items are taken right after reset.
module spiking_neuron_core
    import snc_pkg::*;
#(
    parameter int NEURONS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_in_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output t_out_item        o_out_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    logic  cmd_valid;
    logic  cmd_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_THR_RAISE: begin
                    r_cfg.thr_raise <= i_cfg_data;
                end
                CFG_THR_LOWER: begin
                    r_cfg.thr_lower <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    snc_front #(
        .NEURONS (NEURONS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    snc_back #(
        .NEURONS (NEURONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cfg       (r_cfg),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: bench/spiking_neuron_core_test.sv
// Self-checking testbench for the spiking neuron core with a neuron-table scoreboard.
package snc_bench_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import snc_pkg::*;

    localparam logic [1:0] KIND_IGNORED = 2'd3;

    class neuron_table_scoreboard;
        logic [31:0] membrane   [256];
        logic [31:0] fire_level [256];
        logic [10:0] leak       [256];
        logic [31:0] proximal   [256];
        logic [31:0] distal     [256];
        bit          spiked     [256];
        logic [15:0] raise_amt;
        logic [15:0] lower_amt;
        t_out_item   report_q [$];
        int          errors;

        function new();
            for (int i = 0; i < 256; i++) begin
                membrane[i]   = '0;
                fire_level[i] = '0;
                leak[i]       = '0;
                proximal[i]   = '0;
                distal[i]     = '0;
                spiked[i]     = 1'b0;
            end
            raise_amt = '0;
            lower_amt = '0;
            errors    = 0;
        endfunction

        function void set_reg(t_cfg_reg r, logic [15:0] v);
            if (r == CFG_THR_RAISE) begin
                raise_amt = v;
            end else begin
                lower_amt = v;
            end
        endfunction

        function int pending();
            return report_q.size();
        endfunction

        function void apply_item(t_in_item it);
            logic [7:0]  n;
            longint      prox;
            longint      dsum;
            longint      gain;
            longint      prod;
            logic [31:0] gated;
            logic [31:0] total;
            logic [31:0] decayed;
            logic [31:0] thr_next;
            bit          fire;
            t_out_item   rep;
            n = it.neuron_index;
            case (it.kind)
                KIND_SYNAPSE: begin
                    if (spiked[it.source_index]) begin
                        if (it.compartment == COMP_PROXIMAL) begin
                            proximal[n] += it.weight;
                        end else if (it.compartment == COMP_DISTAL) begin
                            distal[n] += it.weight;
                        end
                    end
                end
                KIND_LOAD: begin
                    fire_level[n] = it.load_threshold;
                    leak[n]       = it.load_decay;
                    membrane[n]   = '0;
                    proximal[n]   = '0;
                    distal[n]     = '0;
                    spiked[n]     = 1'b0;
                end
                KIND_UPDATE: begin
                    prox  = $signed(proximal[n]);
                    dsum  = $signed(distal[n]);
                    gain  = (prox < 64) ? 64 : ((prox > 1024) ? 1024 : prox);
                    prod  = (dsum * gain) >>> 10;
                    gated = prod[31:0];
                    total = membrane[n] + proximal[n] + gated;
                    prod  = (longint'($signed(total)) * (1024 - longint'(leak[n]))) >>> 10;
                    decayed = prod[31:0];
                    fire  = ($signed(decayed) >= $signed(fire_level[n]));
                    if (fire) begin
                        membrane[n] = '0;
                        thr_next    = fire_level[n] + raise_amt;
                    end else begin
                        membrane[n] = decayed;
                        thr_next    = ($signed(fire_level[n]) > 32'sd1024) ?
                                      fire_level[n] - lower_amt : fire_level[n];
                    end
                    fire_level[n] = thr_next;
                    proximal[n]   = '0;
                    distal[n]     = '0;
                    spiked[n]     = fire;
                    rep.out_index     = n;
                    rep.fired         = fire;
                    rep.potential_out = membrane[n];
                    rep.threshold_out = thr_next;
                    report_q.push_back(rep);
                end
                default: ;
            endcase
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;
            if (report_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got neuron %0d", $time,
                         got.out_index);
                errors++;
                return;
            end
            want = report_q.pop_front();
            if (got.out_index !== want.out_index) begin
                $display("%0t: out_index expected %0d got %0d", $time,
                         want.out_index, got.out_index);
                errors++;
            end
            if (got.fired !== want.fired) begin
                $display("%0t: fired expected %0d got %0d", $time, want.fired, got.fired);
                errors++;
            end
            if (got.potential_out !== want.potential_out) begin
                $display("%0t: potential_out expected %0d got %0d", $time,
                         want.potential_out, got.potential_out);
                errors++;
            end
            if (got.threshold_out !== want.threshold_out) begin
                $display("%0t: threshold_out expected %0d got %0d", $time,
                         want.threshold_out, got.threshold_out);
                errors++;
            end
        endfunction
    endclass

endpackage

module spiking_neuron_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import snc_pkg::*;
    import snc_bench_pkg::*;

    localparam int POOL_SIZE    = 12;
    localparam int PHASE_ITEMS  = 390;
    localparam int PHASES       = 5;
    localparam int SETTLE       = 20;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    t_in_item         in_item    = '0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    t_out_item        out_item;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic             cfg_valid  = 1'b0;
    logic             cfg_ready;
    logic [0:0]       cfg_index  = '0;
    logic [CFG_W-1:0] cfg_data   = '0;

    neuron_table_scoreboard board = new();

    bit         loaded [256];
    logic [7:0] pool [POOL_SIZE];
    int         tx_idle_pct = 30;
    int         rx_idle_pct = 30;
    bit         hold_req    = 1'b0;

    spiking_neuron_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_data   (in_item),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .o_out_data  (out_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                board.apply_item(in_item);
            end
            if (out_valid && !out_stall) begin
                board.check_report(out_item);
            end
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    initial begin
        #10ms;
        $display("spiking_neuron_core regression: fail");
        $finish;
    end

    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg r, input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(r, v);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] raise, input logic [CFG_W-1:0] lower);
        write_reg(CFG_THR_RAISE, raise);
        write_reg(CFG_THR_LOWER, lower);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_item(logic [1:0] kind, logic [7:0] src, logic [7:0] idx,
                                           logic [31:0] w, logic [1:0] comp,
                                           logic [31:0] thr, logic [10:0] dec);
        t_in_item it;
        it.kind           = kind;
        it.source_index   = src;
        it.neuron_index   = idx;
        it.weight         = w;
        it.compartment    = comp;
        it.load_threshold = thr;
        it.load_decay     = dec;
        if (kind == KIND_LOAD) begin
            loaded[idx] = 1'b1;
        end
        return it;
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return int'($urandom_range(0, 6000)) - 1500;
        endcase
    endfunction

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 4))
            0, 1:    return int'($urandom_range(0, 4000)) - 2000;
            2:       return $urandom_range(0, 300);
            3:       return $urandom;
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [10:0] pick_decay();
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1:       return 11'd1024;
            2:       return 11'($urandom_range(1025, 2047));
            default: return 11'($urandom_range(0, 1024));
        endcase
    endfunction

    function automatic t_in_item next_random_item();
        t_in_item   it;
        logic [7:0] n;
        int         pick;
        it.kind           = 2'($urandom);
        it.source_index   = 8'($urandom);
        it.neuron_index   = 8'($urandom);
        it.weight         = $urandom;
        it.compartment    = 2'($urandom);
        it.load_threshold = $urandom;
        it.load_decay     = 11'($urandom);
        n    = pool[$urandom_range(0, POOL_SIZE - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            n = 8'($urandom_range(0, 255));
        end
        if (pick < 10 || (pick >= 55 && pick < 92 && !loaded[n])) begin
            it.kind           = KIND_LOAD;
            it.neuron_index   = n;
            it.load_threshold = pick_threshold();
            it.load_decay     = pick_decay();
            loaded[n]         = 1'b1;
        end else if (pick < 55) begin
            it.kind         = KIND_SYNAPSE;
            it.neuron_index = n;
            it.weight       = pick_weight();
            if ($urandom_range(0, 9) != 0) begin
                it.source_index = pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            if ($urandom_range(0, 9) != 0) begin
                it.compartment = 2'($urandom_range(0, 1));
            end else begin
                it.compartment = 2'($urandom_range(2, 3));
            end
        end else if (pick < 92) begin
            it.kind         = KIND_UPDATE;
            it.neuron_index = n;
        end else begin
            it.kind = KIND_IGNORED;
        end
        return it;
    endfunction

    initial begin
        logic [CFG_W-1:0] raise;
        logic [CFG_W-1:0] lower;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        program_regs(16'hFFFF, 16'hFFFF);

        send_item(make_item(KIND_LOAD, 8'd0, 8'd0, 0, COMP_PROXIMAL, -5, 11'd0));
        send_item(make_item(KIND_LOAD, 8'd0, 8'd255, 0, COMP_PROXIMAL, 32'h7FFF_FFFF,
                            11'd1024));
        send_item(make_item(KIND_LOAD, 8'd0, 8'd1, 0, COMP_PROXIMAL, 100, 11'd2047));
        send_item(make_item(KIND_UPDATE, 8'd0, 8'd0, 0, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd0, 8'd1, 32'h7FFF_FFFF, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd0, 8'd1, 32'h8000_0000, COMP_DISTAL, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd0, 8'd1, 5, 2'd2, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd0, 8'd1, 7, 2'd3, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd255, 8'd1, 1000, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_UPDATE, 8'd0, 8'd1, 0, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd0, 8'd255, 32'h7FFF_FFFF, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd0, 8'd255, 32'h7FFF_FFFF, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_UPDATE, 8'd0, 8'd255, 0, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_IGNORED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF,
                            11'h7FF));
        send_item(make_item(KIND_LOAD, 8'd0, 8'd0, 0, COMP_PROXIMAL, 32'h8000_0000, 11'd0));
        send_item(make_item(KIND_UPDATE, 8'd0, 8'd0, 0, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_UPDATE, 8'd0, 8'd0, 0, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd0, 8'd0, 2000, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd0, 8'd0, 3000, COMP_DISTAL, 0, 11'd0));
        send_item(make_item(KIND_UPDATE, 8'd0, 8'd0, 0, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd0, 8'd0, 10, COMP_PROXIMAL, 0, 11'd0));
        send_item(make_item(KIND_SYNAPSE, 8'd0, 8'd0, -3000, COMP_DISTAL, 0, 11'd0));
        send_item(make_item(KIND_UPDATE, 8'd0, 8'd0, 0, COMP_PROXIMAL, 0, 11'd0));

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin raise = '0; lower = '0; end
                1: begin raise = 16'($urandom); lower = 16'($urandom); end
                2: begin raise = 16'hFFFF; lower = '0; end
                3: begin raise = '0; lower = 16'hFFFF; end
                default: begin
                    raise = 16'($urandom_range(1, 64));
                    lower = 16'($urandom_range(1, 64));
                end
            endcase
            tx_idle_pct = (ph == 1) ? 0 : 30;
            rx_idle_pct = (ph == 1) ? 0 : 30;
            foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
            wait_idle(SETTLE);
            program_regs(raise, lower);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == 50) begin
                    hold_req = 1'b1;
                end
                if (ph == 3 && k == 200) begin
                    wait_idle(0);
                end
                send_item(next_random_item());
            end
        end

        wait_idle(SETTLE);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("spiking_neuron_core regression: pass");
        end else begin
            $display("spiking_neuron_core regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/snc_pkg.sv
hw/rtl/snc_front.sv
hw/rtl/snc_back.sv
hw/rtl/spiking_neuron_core.sv
bench/spiking_neuron_core_test.sv
